>>> rtl/all_pairs_shortest_path_engine_macros.svh
// Assertion macros for the all-pairs shortest path engine.
// Depends on nothing. The asserting files include this header.
`ifndef ALL_PAIRS_SHORTEST_PATH_ENGINE_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define APSP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("apsp same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define APSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("apsp next-cycle check failed");

`endif

>>> rtl/apsp_pkg.sv
// Package of the all-pairs shortest path engine: widths, codes, types.
// Depends on nothing; used by the relaxation unit, the top level and the testbench.
`default_nettype none

package apsp_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int NODE_W        = 5;
   localparam int CMD_W         = 2;
   localparam int WEIGHT_W      = 16;
   localparam int DIST_W        = 24;
   localparam int EDGE_W        = 17;

   localparam logic [DIST_W-1:0] UNREACH = 24'hFFFFFF;
   localparam logic [EDGE_W-1:0] NO_EDGE = 17'h1FFFF;

   // Command codes; the last one is not defined and is always rejected.
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Result status codes.
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [3:0] {
      ST_RESET_CLEAR,
      ST_IDLE,
      ST_CLEAR,
      ST_SRC_INIT,
      ST_RELAX,
      ST_TAIL,
      ST_DECIDE,
      ST_QUERY,
      ST_RESPOND
   } apsp_state_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [NODE_W-1:0]   from_node;
      logic [NODE_W-1:0]   to_node;
      logic [WEIGHT_W-1:0] weight;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [DIST_W-1:0]   distance;
      logic [NODE_W-1:0]   predecessor;
   } rsp_type;

   // Sequencer to relaxation unit.
   typedef struct packed {
      logic src_init;
      logic data_valid;
      logic next_pick;
   } relax_ctl_type;

   // Relaxation unit to sequencer.
   typedef struct packed {
      logic done;
   } relax_sts_type;

endpackage

`default_nettype wire

>>> rtl/apsp_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Depends on nothing; holds the edge matrix or the distance table.
`default_nettype none

module apsp_ram #(
   parameter int WIDTH  = 17,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_W];

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

>>> rtl/apsp_relax.sv
// Relaxation unit: settled flags, current pick and the running minimum.
// Depends on apsp_pkg; fed from the edge and distance RAM read ports.
`default_nettype none

module apsp_relax
   import apsp_pkg::*;
#(
   parameter int IDX_W = 5
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire relax_ctl_type            ctl,
   input  wire logic [IDX_W-1:0]         src,
   input  wire logic [IDX_W-1:0]         dw,
   input  wire logic [EDGE_W-1:0]        edge_q,
   input  wire logic [DIST_W+IDX_W-1:0]  dist_q,
   output logic                          wr_en,
   output logic      [DIST_W+IDX_W-1:0]  wr_data,
   output logic      [IDX_W-1:0]         pick,
   output relax_sts_type                 sts
);

   logic [2**IDX_W-1:0] settled_ff, settled_in;
   logic [IDX_W-1:0]    pick_ff, pick_in, cand_ff, cand_in;
   logic [DIST_W-1:0]   best_ff, best_in, min_ff, min_in;
   logic [DIST_W:0]     sum;
   logic [DIST_W-1:0]   sat, cur_d, new_d;
   logic                unsettled, upd;

   // Saturating sum through the picked node and the compare against the table.
   always_comb begin
      cur_d     = dist_q[DIST_W+IDX_W-1:IDX_W];
      unsettled = !settled_ff[dw];
      sum       = {1'b0, best_ff} + (DIST_W+1)'(edge_q);
      sat       = (sum >= {1'b0, UNREACH}) ? UNREACH : sum[DIST_W-1:0];
      upd       = ctl.data_valid && unsettled && (edge_q != NO_EDGE) && (sat < cur_d);
      new_d     = upd ? sat : cur_d;
      wr_en     = upd;
      wr_data   = {sat, pick_ff};
      pick      = pick_ff;
      sts.done  = (cand_ff == '0);
   end

   // Next values of the search registers.
   always_comb begin
      settled_in = settled_ff;
      pick_in    = pick_ff;
      best_in    = best_ff;
      min_in     = min_ff;
      cand_in    = cand_ff;
      priority if (ctl.src_init) begin
         settled_in      = '0;
         settled_in[src] = 1'b1;
         pick_in         = src;
         best_in         = '0;
         min_in          = UNREACH;
         cand_in         = '0;
      end else if (ctl.next_pick) begin
         if (cand_ff != '0) begin
            settled_in[cand_ff] = 1'b1;
            pick_in             = cand_ff;
            best_in             = min_ff;
            min_in              = UNREACH;
            cand_in             = '0;
         end
      end else if (ctl.data_valid) begin
         // Ascending scan with strict compare keeps the lowest node on a tie.
         if (unsettled && (new_d < min_ff)) begin
            min_in  = new_d;
            cand_in = dw;
         end
      end else begin
         // No control this cycle: the candidate is held.
         cand_in = cand_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settled_ff <= '0;
         cand_ff    <= '0;
      end else begin
         settled_ff <= settled_in;
         cand_ff    <= cand_in;
      end
      pick_ff <= pick_in;
      best_ff <= best_in;
      min_ff  <= min_in;
   end

endmodule

`default_nettype wire

>>> rtl/all_pairs_shortest_path_engine.sv
// Top level of the all-pairs shortest path engine: sequencer and RAMs.
// Depends on apsp_pkg, apsp_ram, apsp_relax and the assertion macro header.
//
//  channel   ports                              transaction
//  request   start, busy, req_item              start high while busy low
//  response  rsp_strobe, rsp_item               one cycle, cannot be held off
//  config    csr_write_enable, csr_write_data   every enabled edge
//
// After reset a clearing pass over every address fills both RAMs; busy
// stays high meanwhile. A query or a rejected command answers in the cycle
// after acceptance. An edit clears the distance RAM and then runs the n
// sources in turn, each an init step and then at most n relaxation passes.
// The response strobe is never stalled.
`default_nettype none
`include "all_pairs_shortest_path_engine_macros.svh"

module all_pairs_shortest_path_engine
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  wire logic              csr_write_enable,
   input  wire logic [NODE_W-1:0] csr_write_data
);

   localparam int IDX_W  = $clog2(MAX_NODES + 1);
   localparam int CW     = (IDX_W > NODE_W) ? IDX_W : NODE_W;
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DW     = DIST_W + IDX_W;

   apsp_state_type     state_ff, state_in;
   logic [NODE_W-1:0]  node_count_ff;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   logic [IDX_W-1:0]   src_ff, src_in, w_ff, w_in, dw_ff;
   logic               vld_ff, vld_in;
   logic               status_ff, status_in;

   logic [CW-1:0]      cnt_ext, n_cw, from_cw, to_cw;
   logic [IDX_W-1:0]   n_idx, from_idx, to_idx, pick;
   logic               nodes_ok, req_ok;

   logic               edge_we;
   logic [ADDR_W-1:0]  edge_waddr, edge_raddr;
   logic [EDGE_W-1:0]  edge_wdata, edge_q;
   logic               dist_we, relax_we;
   logic [ADDR_W-1:0]  dist_waddr, dist_raddr;
   logic [DW-1:0]      dist_wdata, dist_q, relax_wdata;

   relax_ctl_type      ctl;
   relax_sts_type      sts;

   // Node range checks against the count capped at MAX_NODES.
   always_comb begin
      cnt_ext  = CW'(node_count_ff);
      n_cw     = (cnt_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : cnt_ext;
      n_idx    = IDX_W'(n_cw);
      from_cw  = CW'(req_item.from_node);
      to_cw    = CW'(req_item.to_node);
      from_idx = IDX_W'(req_item.from_node);
      to_idx   = IDX_W'(req_item.to_node);
      nodes_ok = (from_cw != '0) && (from_cw <= n_cw) && (to_cw != '0) && (to_cw <= n_cw);
      req_ok   = nodes_ok && (req_item.command != CMD_UNUSED)
                 && !((req_item.command == CMD_SET) && (from_idx == to_idx)
                      && (req_item.weight != '0));
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_write_enable) begin
         node_count_ff <= csr_write_data;
      end
   end

   // Sequencer: next state, counters, RAM ports and relaxation control.
   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      src_in     = src_ff;
      w_in       = w_ff;
      vld_in     = 1'b0;
      status_in  = status_ff;
      edge_we    = 1'b0;
      edge_waddr = sweep_ff;
      edge_wdata = NO_EDGE;
      edge_raddr = {pick, w_ff};
      dist_we    = 1'b0;
      dist_waddr = sweep_ff;
      dist_wdata = {UNREACH, {IDX_W{1'b0}}};
      dist_raddr = {src_ff, w_ff};
      ctl        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      rsp_item   = '0;
      unique case (state_ff)
         ST_RESET_CLEAR: begin
            edge_we  = 1'b1;
            dist_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy       = 1'b0;
            dist_raddr = {from_idx, to_idx};
            if (start) begin
               priority if (!req_ok) begin
                  status_in = STATUS_REJECT;
                  state_in  = ST_RESPOND;
               end else if (req_item.command == CMD_QUERY) begin
                  state_in = ST_QUERY;
               end else begin
                  edge_we    = 1'b1;
                  edge_waddr = {from_idx, to_idx};
                  edge_wdata = (req_item.command == CMD_SET) ?
                               {1'b0, req_item.weight} : NO_EDGE;
                  status_in  = STATUS_OK;
                  sweep_in   = '0;
                  state_in   = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            dist_we  = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (&sweep_ff) begin
               src_in   = IDX_W'(1);
               state_in = ST_SRC_INIT;
            end
         end
         ST_SRC_INIT: begin
            // A source reaches itself at distance zero with no predecessor.
            dist_we      = 1'b1;
            dist_waddr   = {src_ff, src_ff};
            dist_wdata   = '0;
            ctl.src_init = 1'b1;
            w_in         = IDX_W'(1);
            state_in     = ST_RELAX;
         end
         ST_RELAX: begin
            vld_in = 1'b1;
            if (w_ff == n_idx) begin
               state_in = ST_TAIL;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            ctl.next_pick = 1'b1;
            if (sts.done) begin
               if (src_ff == n_idx) begin
                  state_in = ST_RESPOND;
               end else begin
                  src_in   = src_ff + 1'b1;
                  state_in = ST_SRC_INIT;
               end
            end else begin
               w_in     = IDX_W'(1);
               state_in = ST_RELAX;
            end
         end
         ST_QUERY: begin
            rsp_strobe           = 1'b1;
            rsp_item.status      = STATUS_OK;
            rsp_item.distance    = dist_q[DW-1:IDX_W];
            rsp_item.predecessor = NODE_W'(dist_q[IDX_W-1:0]);
            state_in             = ST_IDLE;
         end
         ST_RESPOND: begin
            rsp_strobe      = 1'b1;
            rsp_item.status = status_ff;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // Relaxation write-back of the item read in the previous cycle.
      ctl.data_valid = vld_ff;
      if (relax_we) begin
         dist_we    = 1'b1;
         dist_waddr = {src_ff, dw_ff};
         dist_wdata = relax_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RESET_CLEAR;
         sweep_ff <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         vld_ff   <= vld_in;
      end
      src_ff    <= src_in;
      w_ff      <= w_in;
      dw_ff     <= w_ff;
      status_ff <= status_in;
   end

   // Edge matrix, addressed by from and to node.
   apsp_ram #(
      .WIDTH  (EDGE_W),
      .ADDR_W (ADDR_W)
   ) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .raddr (edge_raddr),
      .rdata (edge_q)
   );

   // Distance and predecessor table, addressed by source and node.
   apsp_ram #(
      .WIDTH  (DW),
      .ADDR_W (ADDR_W)
   ) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .raddr (dist_raddr),
      .rdata (dist_q)
   );

   apsp_relax #(
      .IDX_W (IDX_W)
   ) u_relax (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .src     (src_ff),
      .dw      (dw_ff),
      .edge_q  (edge_q),
      .dist_q  (dist_q),
      .wr_en   (relax_we),
      .wr_data (relax_wdata),
      .pick    (pick),
      .sts     (sts)
   );

   // Checks on the sequencer.
   `APSP_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `APSP_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe)
   `APSP_ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy)
   `APSP_ASSERT_SAME(a_relax_window, clock, reset, relax_we, state_ff == ST_RELAX || state_ff == ST_TAIL)

endmodule

`default_nettype wire

>>> verif/tb_all_pairs_shortest_path_engine.sv
// Self-checking testbench for the all-pairs shortest path engine.
// Depends on apsp_pkg and the engine RTL; it predicts every response itself.
`timescale 1ns / 1ps

module tb_all_pairs_shortest_path_engine;
   import apsp_pkg::*;

   localparam int SIDE  = MAX_NODES_DEF + 1;
   localparam int CELLS = SIDE * SIDE;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_item;
   logic              rsp_strobe;
   rsp_type           rsp_item;
   logic              csr_write_enable;
   logic [NODE_W-1:0] csr_write_data;

   // Shadow copy of the engine state.
   logic [NODE_W-1:0] node_count_shadow;
   logic [EDGE_W-1:0] edge_shadow [0:CELLS-1];
   logic [DIST_W-1:0] dist_shadow [0:CELLS-1];
   logic [NODE_W-1:0] pred_shadow [0:CELLS-1];

   rsp_type expected_rsp_q[$];
   int      mismatch_count;

   all_pairs_shortest_path_engine dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_item         (req_item),
      .rsp_strobe       (rsp_strobe),
      .rsp_item         (rsp_item),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic int active_nodes();
      return (node_count_shadow > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(node_count_shadow);
   endfunction

   // Single-source search: settle the closest unsettled node, lowest number on a tie.
   function automatic void search_from(int src, int n);
      bit          settled [0:SIDE-1];
      int          row;
      int          pick;
      int unsigned closest;
      int unsigned cost;
      int unsigned sum;
      row = src * SIDE;
      foreach (settled[i]) settled[i] = 1'b0;
      dist_shadow[row + src] = '0;
      forever begin
         pick = 0;
         closest = UNREACH;
         for (int i = 1; i <= n; i++) begin
            if (!settled[i] && dist_shadow[row + i] < closest) begin
               closest = dist_shadow[row + i];
               pick = i;
            end
         end
         if (pick == 0) break;
         settled[pick] = 1'b1;
         for (int w = 1; w <= n; w++) begin
            cost = edge_shadow[pick * SIDE + w];
            if (w == pick || settled[w] || cost == NO_EDGE) continue;
            sum = closest + cost;
            if (sum > UNREACH) sum = UNREACH;
            if (sum < dist_shadow[row + w]) begin
               dist_shadow[row + w] = sum[DIST_W-1:0];
               pred_shadow[row + w] = pick[NODE_W-1:0];
            end
         end
      end
   endfunction

   // Every edit clears both tables and searches again from each source.
   function automatic void refresh_paths();
      int n;
      n = active_nodes();
      for (int i = 0; i < CELLS; i++) begin
         dist_shadow[i] = UNREACH;
         pred_shadow[i] = '0;
      end
      for (int s = 1; s <= n; s++) search_from(s, n);
   endfunction

   // Work out the response for one accepted transaction and update the shadow.
   function automatic rsp_type predict_response(req_type item);
      rsp_type outcome;
      int      n;
      int      a;
      int      b;
      bit      ok;
      n = active_nodes();
      a = item.from_node;
      b = item.to_node;
      outcome.status = STATUS_REJECT;
      outcome.distance = '0;
      outcome.predecessor = '0;
      ok = a >= 1 && a <= n && b >= 1 && b <= n &&
           (item.command == CMD_SET || item.command == CMD_REMOVE ||
            item.command == CMD_QUERY);
      if (ok && item.command == CMD_SET && a == b && item.weight != 0) ok = 1'b0;
      if (!ok) return outcome;
      outcome.status = STATUS_OK;
      if (item.command == CMD_SET) begin
         edge_shadow[a * SIDE + b] = {1'b0, item.weight};
         refresh_paths();
      end else if (item.command == CMD_REMOVE) begin
         edge_shadow[a * SIDE + b] = NO_EDGE;
         refresh_paths();
      end else begin
         outcome.distance = dist_shadow[a * SIDE + b];
         outcome.predecessor = pred_shadow[a * SIDE + b];
      end
      return outcome;
   endfunction

   // Compare each response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response status=%0d distance=%0d predecessor=%0d",
                        rsp_item.status, rsp_item.distance, rsp_item.predecessor);
         end else begin
            if (rsp_item !== expected_rsp_q[0]) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                           expected_rsp_q[0].status, expected_rsp_q[0].distance,
                           expected_rsp_q[0].predecessor, rsp_item.status,
                           rsp_item.distance, rsp_item.predecessor);
            end
            void'(expected_rsp_q.pop_front());
         end
      end
   end

   // Offer one transaction, wait for acceptance, then idle for a random gap.
   task automatic send_command(logic [CMD_W-1:0] cmd, int a, int b, int w);
      req_type item;
      int      gap;
      item.command = cmd;
      item.from_node = a[NODE_W-1:0];
      item.to_node = b[NODE_W-1:0];
      item.weight = w[WEIGHT_W-1:0];
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(predict_response(item));
      start <= 1'b0;
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      repeat (gap) @(posedge clock);
   endtask

   // Node count is only changed once all responses are in.
   task automatic write_node_count(int value);
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[NODE_W-1:0];
      @(posedge clock);
      node_count_shadow = value[NODE_W-1:0];
      csr_write_enable <= 1'b0;
   endtask

   task automatic test_rejects();
      send_command(CMD_QUERY, 1, 1, 0);
      write_node_count(4);
      send_command(CMD_QUERY, 1, 1, 0);
      send_command(CMD_SET, 0, 2, 5);
      send_command(CMD_SET, 2, 5, 5);
      send_command(CMD_QUERY, 31, 1, 0);
      send_command(CMD_REMOVE, 1, 0, 0);
      send_command(CMD_SET, 3, 3, 7);
      send_command(CMD_UNUSED, 1, 2, 0);
   endtask

   task automatic test_small_graph();
      send_command(CMD_SET, 1, 2, 10);
      send_command(CMD_SET, 2, 3, 5);
      send_command(CMD_SET, 1, 3, 20);
      send_command(CMD_SET, 3, 3, 0);
      send_command(CMD_SET, 3, 4, 65535);
      send_command(CMD_QUERY, 1, 3, 1234);
      send_command(CMD_QUERY, 1, 4, 0);
      send_command(CMD_QUERY, 4, 1, 0);
      send_command(CMD_QUERY, 2, 2, 0);
      send_command(CMD_REMOVE, 2, 3, 999);
      send_command(CMD_QUERY, 1, 3, 0);
   endtask

   // Shrinking the count keeps old tables; oversized counts act as the maximum.
   task automatic test_count_changes();
      write_node_count(2);
      send_command(CMD_QUERY, 1, 2, 0);
      send_command(CMD_QUERY, 1, 3, 0);
      write_node_count(31);
      send_command(CMD_QUERY, 1, 4, 0);
      send_command(CMD_SET, 16, 1, 1);
      send_command(CMD_SET, 4, 16, 65535);
      send_command(CMD_QUERY, 3, 1, 0);
      send_command(CMD_QUERY, 16, 16, 0);
   endtask

   // Mostly well-formed edits and queries, with some malformed transactions.
   task automatic test_random(int count);
      int n;
      int pick;
      int a;
      int b;
      int w;
      n = active_nodes();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         a = $urandom_range(1, (n < 1) ? 1 : n);
         b = $urandom_range(1, (n < 1) ? 1 : n);
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
         if (pick < 40) send_command(CMD_QUERY, a, b, $urandom_range(0, 65535));
         else if (pick < 68) send_command(CMD_SET, a, b, (a == b) ? 0 : w);
         else if (pick < 82) send_command(CMD_REMOVE, a, b, $urandom_range(0, 65535));
         else send_command(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                           $urandom_range(0, 31), $urandom_range(0, 65535));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      mismatch_count = 0;
      node_count_shadow = '0;
      for (int i = 0; i < CELLS; i++) begin
         edge_shadow[i] = NO_EDGE;
         dist_shadow[i] = UNREACH;
         pred_shadow[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_rejects();
      test_small_graph();
      test_count_changes();
      write_node_count(0);
      test_random(6);
      write_node_count(1);
      test_random(8);
      write_node_count(5);
      test_random(40);
      write_node_count(16);
      test_random(25);
      write_node_count(17);
      test_random(15);
      write_node_count(3);
      test_random(20);

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_all_pairs_shortest_path_engine: done, clean");
      end else begin
         $display("tb_all_pairs_shortest_path_engine: done, errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #8000000;
      $display("tb_all_pairs_shortest_path_engine: done, errors");
      $finish;
   end

endmodule

>>> all_pairs_shortest_path_engine.f
+incdir+rtl
rtl/apsp_pkg.sv
rtl/apsp_ram.sv
rtl/apsp_relax.sv
rtl/all_pairs_shortest_path_engine.sv
verif/tb_all_pairs_shortest_path_engine.sv
